### src/swtf_pkg.sv
package swtf_pkg;

    // Default sizing of the sample store
    localparam int BINS_DEF        = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int LAG_W   = 7;
    localparam int THR_W   = 17;
    localparam int KIND_W  = 2;
    localparam int POS_W   = 7;
    localparam int COUNT_W = 5;
    localparam int CFG_IDX_W = 1;

    // Register reset values and limits
    localparam logic [LAG_W-1:0]   LAG_RESET       = 7'd7;
    localparam logic [THR_W-1:0]   THR_RESET       = 17'd1024;
    localparam logic [COUNT_W-1:0] MAX_PER_KIND    = 5'd30;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAG       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_RISE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FALL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_TAIL,
        ST_END
    } t_state;

endpackage

### src/swtf_ram.sv
module swtf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read two with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### src/square_wave_transition_finder.sv
// Loading accepts a sample whenever busy is low; busy stays low between samples of a frame.
// After the frame_end sample: the lag remainder (bit-serial divider), then two passes
// over the store (one read pair a cycle, each closed by a tail step), then the end item;
// the passes are skipped for frames under three samples or a zero threshold.
// Results appear in the cycle after they are found; the receiver cannot stall them.
// Synchronous reset clears counts, flags and registers to defaults, not the store.
module square_wave_transition_finder #(
    parameter int BINS        = swtf_pkg::BINS_DEF,
    parameter int SAMPLE_BITS = swtf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_frame_end,
    input  logic                              i_cfg_we,
    input  logic [swtf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [swtf_pkg::THR_W-1:0]        i_cfg_data,
    output logic                              o_strobe,
    output logic [swtf_pkg::KIND_W-1:0]       o_kind,
    output logic [swtf_pkg::POS_W-1:0]        o_position,
    output logic [swtf_pkg::COUNT_W-1:0]      o_pair_count,
    output logic                              o_truncated,
    output logic                              o_last
);

    localparam int AW = $clog2(BINS);
    localparam int CW = $clog2(BINS + 1);
    localparam int DW = ((SAMPLE_BITS + 1) > (swtf_pkg::THR_W + 1) ?
                         (SAMPLE_BITS + 1) : (swtf_pkg::THR_W + 1)) + 1;

    swtf_pkg::t_state r_state, n_state;

    logic [swtf_pkg::LAG_W-1:0]   r_lag;
    logic [swtf_pkg::THR_W-1:0]   r_thr;
    logic [CW-1:0]                r_fill;
    logic                         r_ovf;
    logic [swtf_pkg::COUNT_W-1:0] r_cnt_rise;
    logic [swtf_pkg::COUNT_W-1:0] r_cnt_fall;

    logic [2:0]    r_bit;
    logic [7:0]    r_rem;
    logic [CW-1:0] r_off;

    logic          r_pass;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic          r_iss_done;
    logic          r_pv;
    logic [CW-1:0] r_pidx;
    logic          r_in_ev;
    logic [CW-1:0] r_start;
    logic [1:0]    r_quiet;

    logic [SAMPLE_BITS-1:0] rd_a;
    logic [SAMPLE_BITS-1:0] rd_b;

    logic accept;
    logic store_ok;
    logic skip_scan;
    logic issue;
    logic last_proc;
    logic [7:0] rem_shift;
    logic [7:0] rem_next;

    logic signed [DW-1:0] d_val;
    logic signed [DW-1:0] thr_s;
    logic hit;
    logic quiet_now;
    logic [1:0] q_inc;

    logic                         emit;
    logic [swtf_pkg::KIND_W-1:0]  emit_kind;
    logic [7:0]                   pos_sum;
    logic [swtf_pkg::COUNT_W-1:0] cur_cnt;
    logic                         can_emit;
    logic                         ev_set;
    logic                         ev_clr;
    logic                         end_item;

    assign busy      = (r_state != swtf_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign store_ok  = (r_fill < CW'(BINS));
    assign skip_scan = (r_fill < CW'(3)) || (r_thr == '0);

    // Sample store
    swtf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BINS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (accept && store_ok),
        .i_waddr   (r_fill[AW-1:0]),
        .i_wdata   (i_sample),
        .i_raddr_a (r_j[AW-1:0]),
        .i_raddr_b (r_i[AW-1:0]),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Restoring remainder step: lag mod n, one lag bit a cycle
    assign rem_shift = {r_rem[6:0], r_lag[r_bit]};
    assign rem_next  = (rem_shift >= 8'(r_fill)) ? (rem_shift - 8'(r_fill)) : rem_shift;

    // Lagged difference and threshold compares
    assign d_val     = DW'($signed(rd_a)) - DW'($signed(rd_b));
    assign thr_s     = $signed(DW'(r_thr));
    assign hit       = r_pass ? (d_val < -thr_s) : (d_val > thr_s);
    assign quiet_now = (d_val < thr_s) && (d_val > -thr_s);
    assign q_inc     = quiet_now ? (r_quiet + 2'd1) : 2'd0;

    assign issue     = (r_state == swtf_pkg::ST_SCAN) && !r_iss_done;
    assign last_proc = (r_state == swtf_pkg::ST_SCAN) && r_pv && (r_pidx == r_fill - CW'(1));
    assign cur_cnt   = r_pass ? r_cnt_fall : r_cnt_rise;
    assign can_emit  = (cur_cnt < swtf_pkg::MAX_PER_KIND);
    assign emit_kind = r_pass ? swtf_pkg::KIND_FALL : swtf_pkg::KIND_RISE;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swtf_pkg::ST_IDLE: begin
                if (accept && i_frame_end) begin
                    n_state = swtf_pkg::ST_MOD;
                end
            end
            swtf_pkg::ST_MOD: begin
                if (r_bit == 3'd0) begin
                    n_state = skip_scan ? swtf_pkg::ST_END : swtf_pkg::ST_SCAN;
                end
            end
            swtf_pkg::ST_SCAN: begin
                if (last_proc) begin
                    n_state = swtf_pkg::ST_TAIL;
                end
            end
            swtf_pkg::ST_TAIL: begin
                n_state = r_pass ? swtf_pkg::ST_END : swtf_pkg::ST_SCAN;
            end
            swtf_pkg::ST_END: begin
                n_state = swtf_pkg::ST_IDLE;
            end
            default: begin
                n_state = swtf_pkg::ST_IDLE;
            end
        endcase
    end

    // Scan decisions and result selection
    always_comb begin
        emit     = 1'b0;
        ev_set   = 1'b0;
        ev_clr   = 1'b0;
        end_item = 1'b0;
        pos_sum  = 8'(r_start) + 8'(r_pidx) - 8'd3;
        unique case (r_state)
            swtf_pkg::ST_SCAN: begin
                if (r_pv) begin
                    if (!r_in_ev) begin
                        ev_set = hit;
                    end else if (q_inc == 2'd3) begin
                        ev_clr = 1'b1;
                        emit   = can_emit;
                    end
                end
            end
            swtf_pkg::ST_TAIL: begin
                pos_sum = 8'(r_start) + 8'(r_fill) - 8'd3;
                emit    = r_in_ev && can_emit;
                ev_clr  = 1'b1;
            end
            swtf_pkg::ST_END: begin
                end_item = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= swtf_pkg::ST_IDLE;
            r_lag      <= swtf_pkg::LAG_RESET;
            r_thr      <= swtf_pkg::THR_RESET;
            r_fill     <= '0;
            r_ovf      <= 1'b0;
            r_cnt_rise <= '0;
            r_cnt_fall <= '0;
            r_pass     <= 1'b0;
            r_iss_done <= 1'b0;
            r_pv       <= 1'b0;
            r_in_ev    <= 1'b0;
            r_quiet    <= 2'd0;
            r_bit      <= 3'd0;
            o_strobe   <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    swtf_pkg::REG_LAG:       r_lag <= i_cfg_data[swtf_pkg::LAG_W-1:0];
                    swtf_pkg::REG_THRESHOLD: r_thr <= i_cfg_data;
                    default:                 r_lag <= r_lag;
                endcase
            end

            // Count stored samples, flag dropped ones
            if (accept) begin
                if (store_ok) begin
                    r_fill <= r_fill + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
                if (i_frame_end) begin
                    r_bit <= 3'(swtf_pkg::LAG_W - 1);
                    r_rem <= 8'd0;
                end
            end

            // Advance the remainder and arm the first pass
            if (r_state == swtf_pkg::ST_MOD) begin
                r_rem <= rem_next;
                r_bit <= r_bit - 3'd1;
                if (r_bit == 3'd0) begin
                    r_off      <= rem_next[CW-1:0];
                    r_j        <= rem_next[CW-1:0];
                    r_i        <= '0;
                    r_pass     <= 1'b0;
                    r_iss_done <= 1'b0;
                    r_in_ev    <= 1'b0;
                    r_quiet    <= 2'd0;
                end
            end

            // Issue read pairs
            r_pv   <= issue;
            r_pidx <= r_i;
            if (issue) begin
                r_i <= r_i + CW'(1);
                r_j <= (r_j == r_fill - CW'(1)) ? '0 : r_j + CW'(1);
                if (r_i == r_fill - CW'(1)) begin
                    r_iss_done <= 1'b1;
                end
            end

            // Track the open crossing
            if (ev_set) begin
                r_in_ev <= 1'b1;
                r_start <= r_pidx;
                r_quiet <= 2'd0;
            end else if (ev_clr) begin
                r_in_ev <= 1'b0;
                r_quiet <= 2'd0;
            end else if (r_state == swtf_pkg::ST_SCAN && r_pv && r_in_ev) begin
                r_quiet <= q_inc;
            end

            // Rearm for the falling pass
            if (r_state == swtf_pkg::ST_TAIL && !r_pass) begin
                r_pass     <= 1'b1;
                r_i        <= '0;
                r_j        <= r_off;
                r_iss_done <= 1'b0;
            end

            // Count emitted transitions per kind
            if (emit) begin
                if (r_pass) begin
                    r_cnt_fall <= r_cnt_fall + swtf_pkg::COUNT_W'(1);
                end else begin
                    r_cnt_rise <= r_cnt_rise + swtf_pkg::COUNT_W'(1);
                end
            end

            // Drive one result transfer
            o_strobe <= emit || end_item;
            if (end_item) begin
                r_fill     <= '0;
                r_ovf      <= 1'b0;
                r_cnt_rise <= '0;
                r_cnt_fall <= '0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (end_item) begin
            o_kind       <= swtf_pkg::KIND_END;
            o_position   <= '0;
            o_pair_count <= (r_cnt_rise < r_cnt_fall) ? r_cnt_rise : r_cnt_fall;
            o_truncated  <= r_ovf;
            o_last       <= 1'b1;
        end else if (emit) begin
            o_kind       <= emit_kind;
            o_position   <= pos_sum[7:1];
            o_pair_count <= '0;
            o_truncated  <= 1'b0;
            o_last       <= 1'b0;
        end
    end

endmodule

### sim/tb_square_wave_transition_finder.sv
module tb_square_wave_transition_finder;

    localparam int STORE_DEPTH = swtf_pkg::BINS_DEF;

    typedef struct packed {
        logic [swtf_pkg::KIND_W-1:0]  kind;
        logic [swtf_pkg::POS_W-1:0]   position;
        logic [swtf_pkg::COUNT_W-1:0] pair_count;
        logic                         truncated;
        logic                         last;
    } t_edge_mark;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic signed [15:0]                  i_sample;
    logic                                i_frame_end;
    logic                                i_cfg_we;
    logic [swtf_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [swtf_pkg::THR_W-1:0]          i_cfg_data;
    logic                                o_strobe;
    logic [swtf_pkg::KIND_W-1:0]         o_kind;
    logic [swtf_pkg::POS_W-1:0]          o_position;
    logic [swtf_pkg::COUNT_W-1:0]        o_pair_count;
    logic                                o_truncated;
    logic                                o_last;

    // Predictor copy of the block state
    logic signed [15:0]                  profile_bins [STORE_DEPTH];
    int                                  lag_diff [STORE_DEPTH];
    int                                  bins_loaded;
    bit                                  bins_dropped;
    logic [swtf_pkg::LAG_W-1:0]          cur_lag;
    logic [swtf_pkg::THR_W-1:0]          cur_thr;

    t_edge_mark                          marks_due [$];
    int                                  fail_count;
    bit                                  sender_gaps;

    square_wave_transition_finder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_sample     (i_sample),
        .i_frame_end  (i_frame_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_position   (o_position),
        .o_pair_count (o_pair_count),
        .o_truncated  (o_truncated),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    // One pass over the differences: rising or falling, queueing each midpoint found
    function automatic int scan_pass(bit rising, int n);
        int  thr;
        int  found;
        int  run_start;
        int  quiet;
        int  mag;
        bit  hit;
        t_edge_mark mark;
        thr   = int'(cur_thr);
        found = 0;
        if (n < 3 || thr == 0)
            return 0;
        for (int i = 0; i < n; i++) begin
            hit = rising ? (lag_diff[i] > thr) : (lag_diff[i] < -thr);
            if (!hit)
                continue;
            run_start = i;
            quiet     = 0;
            // hold the crossing until three quiet bins in a row, or the frame ends
            while (i < n) begin
                mag = (lag_diff[i] < 0) ? -lag_diff[i] : lag_diff[i];
                if (mag < thr)
                    quiet++;
                else
                    quiet = 0;
                if (quiet > 2)
                    break;
                i++;
            end
            if (found < int'(swtf_pkg::MAX_PER_KIND)) begin
                mark.kind       = rising ? swtf_pkg::KIND_RISE : swtf_pkg::KIND_FALL;
                mark.position   = swtf_pkg::POS_W'((run_start + i - 3) / 2);
                mark.pair_count = '0;
                mark.truncated  = 1'b0;
                mark.last       = 1'b0;
                marks_due       = {marks_due, mark};
                found++;
            end
        end
        return found;
    endfunction

    // Store one accepted sample; on frame end work out the transitions and the end item
    task automatic predict_marks(input logic signed [15:0] value, input bit frame_end);
        int         n;
        int         shift;
        int         rises;
        int         falls;
        t_edge_mark mark;
        if (bins_loaded < STORE_DEPTH) begin
            profile_bins[bins_loaded] = value;
            bins_loaded++;
        end else begin
            bins_dropped = 1'b1;
        end
        if (!frame_end)
            return;
        n     = bins_loaded;
        shift = int'(cur_lag) % n;
        for (int i = 0; i < n; i++)
            lag_diff[i] = int'(profile_bins[(i + shift) % n]) - int'(profile_bins[i]);
        rises = scan_pass(1'b1, n);
        falls = scan_pass(1'b0, n);
        mark.kind       = swtf_pkg::KIND_END;
        mark.position   = '0;
        mark.pair_count = swtf_pkg::COUNT_W'((rises < falls) ? rises : falls);
        mark.truncated  = bins_dropped;
        mark.last       = 1'b1;
        marks_due       = {marks_due, mark};
        bins_loaded  = 0;
        bins_dropped = 1'b0;
    endtask

    // Transfer one sample, then maybe idle for a short burst
    task automatic send_sample(input logic signed [15:0] value, input bit frame_end);
        start       <= 1'b1;
        i_sample    <= value;
        i_frame_end <= frame_end;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_marks(value, frame_end);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every expected result has arrived
    task automatic settle();
        start <= 1'b0;
        while (marks_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [swtf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swtf_pkg::THR_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == swtf_pkg::REG_LAG)
            cur_lag = value[swtf_pkg::LAG_W-1:0];
        else
            cur_thr = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Square wave with random period, duty, levels and jitter
    task automatic send_square_frame(input int len);
        int period;
        int high_len;
        int shift;
        int lo;
        int hi;
        int jitter;
        int v;
        period   = $urandom_range(4, 16);
        high_len = $urandom_range(1, period - 1);
        shift    = $urandom_range(0, period - 1);
        lo       = int'($urandom_range(0, 40000)) - 32768;
        hi       = lo + int'($urandom_range(0, 65535));
        jitter   = $urandom_range(0, 300);
        for (int k = 0; k < len; k++) begin
            v = (((k + shift) % period) < high_len) ? hi : lo;
            v = v + int'($urandom_range(0, 2 * jitter)) - jitter;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            send_sample(v[15:0], k == len - 1);
        end
    endtask

    // Frames too short to hold a transition
    task automatic test_short_frames();
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
    endtask

    // Full-scale step: one rising edge resolved, one falling edge cut by the frame end
    task automatic test_full_scale_step();
        settle();
        write_reg(swtf_pkg::REG_LAG, swtf_pkg::THR_W'(1));
        write_reg(swtf_pkg::REG_THRESHOLD, swtf_pkg::THR_W'(1000));
        for (int k = 0; k < 8; k++)
            send_sample((k < 4) ? 16'sh8000 : 16'sh7FFF, k == 7);
    endtask

    task automatic test_zero_threshold();
        settle();
        write_reg(swtf_pkg::REG_THRESHOLD, '0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b1);
    endtask

    // Lag far beyond the frame length wraps round the frame
    task automatic test_lag_wrap();
        settle();
        write_reg(swtf_pkg::REG_LAG, swtf_pkg::THR_W'(119));
        write_reg(swtf_pkg::REG_THRESHOLD, swtf_pkg::THR_W'(100));
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh1388, 1'b0);
        send_sample(16'sh1388, 1'b0);
        send_sample(16'sh1388, 1'b1);
    endtask

    // Phases of random settings, mostly square-wave frames, one frame over the store
    task automatic test_random_frames();
        int         sent;
        int         len;
        bit [31:0]  noise;
        for (int ph = 0; ph < 7; ph++) begin
            settle();
            if (ph == 0)
                write_reg(swtf_pkg::REG_LAG, '0);
            else if (ph == 5)
                write_reg(swtf_pkg::REG_LAG, swtf_pkg::THR_W'(119));
            else
                write_reg(swtf_pkg::REG_LAG, swtf_pkg::THR_W'($urandom_range(0, 119)));
            if (ph == 1)
                write_reg(swtf_pkg::REG_THRESHOLD, swtf_pkg::THR_W'(131071));
            else
                write_reg(swtf_pkg::REG_THRESHOLD,
                          swtf_pkg::THR_W'($urandom_range(100, 20000)));
            sent = 0;
            if (ph == 3) begin
                len = STORE_DEPTH + $urandom_range(1, 4);
                send_square_frame(len);
                sent += len;
            end
            while (sent < 6) begin
                // no idling in the last phase
                sender_gaps = (ph != 6) && ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 6) != 0) begin
                    len = $urandom_range(3, 20);
                    send_square_frame(len);
                end else begin
                    len = $urandom_range(1, 8);
                    for (int k = 0; k < len; k++) begin
                        noise = $urandom();
                        send_sample(noise[15:0], k == len - 1);
                    end
                end
                sent += len;
            end
        end
    endtask

    // Compare one field, report on mismatch
    function automatic int field_miss(string fname, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Check every result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_edge_mark want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (marks_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d position %0d",
                         $time, o_kind, o_position);
                fail_count++;
            end else begin
                want = marks_due.pop_front();
                fail_count += field_miss("kind", want.kind, o_kind);
                fail_count += field_miss("position", want.position, o_position);
                fail_count += field_miss("pair_count", want.pair_count, o_pair_count);
                fail_count += field_miss("truncated", want.truncated, o_truncated);
                fail_count += field_miss("last", want.last, o_last);
            end
        end
    end

    initial begin
        start        <= 1'b0;
        i_sample     <= '0;
        i_frame_end  <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= swtf_pkg::REG_LAG;
        i_cfg_data   <= '0;
        i_rst_n      <= 1'b0;
        fail_count   = 0;
        sender_gaps  = 1'b1;
        bins_loaded  = 0;
        bins_dropped = 1'b0;
        cur_lag      = swtf_pkg::LAG_RESET;
        cur_thr      = swtf_pkg::THR_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_frames();
        test_full_scale_step();
        test_zero_threshold();
        test_lag_wrap();
        test_random_frames();

        // drain, then allow for any stray result
        settle();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
src/swtf_pkg.sv
src/swtf_ram.sv
src/square_wave_transition_finder.sv
sim/tb_square_wave_transition_finder.sv
